/* sv/wfq_pkg.sv */
`timescale 1ns / 1ps

package wfq_pkg;

  localparam int QueueDepth = 32;
  localparam int NumLanes   = 8;
  localparam int NumWarps   = 8;
  localparam int PcWidth    = 32;

  localparam int PtrW   = $clog2(QueueDepth);
  localparam int CntW   = $clog2(QueueDepth + 1);
  localparam int MaskW  = 8;
  localparam int WarpW  = 3;
  localparam int LaneCntW = 4;
  localparam int HaltW  = 8;
  localparam int QueuedW = 6;

  localparam logic [MaskW-1:0] LaneKeep = {MaskW{1'b1}} >> (MaskW - NumLanes);
  localparam logic [31:0] PcKeep = {32{1'b1}} >> (32 - PcWidth);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic                cmd;
    logic [31:0]         next_pc;
    logic [MaskW-1:0]    lane_mask;
    logic [WarpW-1:0]    warp_num;
    logic [LaneCntW-1:0] lane_count;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [31:0]         fetch_pc;
    logic [WarpW-1:0]    fetch_warp;
    logic [MaskW-1:0]    fetch_mask;
    logic [LaneCntW-1:0] fetch_lane_count;
    logic                warp_halted;
    logic [HaltW-1:0]    halt_bits;
    logic [QueuedW-1:0]  queued;
  } out_t;

  typedef struct packed {
    logic [31:0]         pc;
    logic [MaskW-1:0]    mask;
    logic [WarpW-1:0]    warp;
    logic [LaneCntW-1:0] count;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic    store;      // write the pushed request
    logic    rd_issue;   // read the head entry
    logic    pop_commit; // retire the head entry, update halt tracking
    logic    load_out;   // capture a result beat
    status_e out_status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
  } dp_sts_t;

endpackage

/* sv/wfq_ctrl.sv */
`timescale 1ns / 1ps

module wfq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  wfq_pkg::dp_sts_t  sts_i,
  output wfq_pkg::dp_cmd_t  cmd_o
);

  wfq_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;
  logic in_fire;

  // result slot is free if empty or being drained this cycle
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == wfq_pkg::ST_IDLE) && slot_free;
  assign in_fire = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      wfq_pkg::ST_IDLE: begin
        if (in_fire && in_cmd_i == wfq_pkg::CMD_POP && !sts_i.empty) begin
          state_d = wfq_pkg::ST_READ;
        end
      end
      wfq_pkg::ST_READ: begin
        if (slot_free) begin
          state_d = wfq_pkg::ST_IDLE;
        end
      end
      default: state_d = wfq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.out_status = wfq_pkg::STATUS_OK;
    case (state_q)
      wfq_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd_i == wfq_pkg::CMD_PUSH) begin
            cmd_o.load_out = 1'b1;
            if (sts_i.full) begin
              cmd_o.out_status = wfq_pkg::STATUS_FULL;
            end else begin
              cmd_o.store = 1'b1;
            end
          end else if (sts_i.empty) begin
            cmd_o.load_out   = 1'b1;
            cmd_o.out_status = wfq_pkg::STATUS_EMPTY;
          end else begin
            cmd_o.rd_issue = 1'b1;
          end
        end
      end
      wfq_pkg::ST_READ: begin
        if (slot_free) begin
          cmd_o.pop_commit = 1'b1;
          cmd_o.load_out   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wfq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* sv/wfq_datapath.sv */
`timescale 1ns / 1ps

module wfq_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wfq_pkg::in_t      in_data_i,
  input  wfq_pkg::dp_cmd_t  cmd_i,
  output wfq_pkg::dp_sts_t  sts_o,
  output wfq_pkg::out_t     out_data_o
);

  wfq_pkg::entry_t mem [wfq_pkg::QueueDepth];
  wfq_pkg::entry_t rdata_q;
  wfq_pkg::entry_t wr_entry;

  logic [wfq_pkg::PtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [wfq_pkg::CntW-1:0]  count_q, count_d;
  logic [31:0]               last_pc_q, last_pc_d;
  logic [wfq_pkg::WarpW-1:0] last_warp_q, last_warp_d;
  logic [wfq_pkg::MaskW-1:0] last_mask_q, last_mask_d;
  logic                      last_valid_q, last_valid_d;
  logic [wfq_pkg::HaltW-1:0] halt_q, halt_d;
  logic                      repeat_hit;
  wfq_pkg::out_t             out_q, out_d;

  function automatic logic [wfq_pkg::PtrW-1:0] ring_next(logic [wfq_pkg::PtrW-1:0] p);
    if (p == wfq_pkg::PtrW'(wfq_pkg::QueueDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign sts_o.full  = (count_q == wfq_pkg::CntW'(wfq_pkg::QueueDepth));
  assign sts_o.empty = (count_q == '0);

  always_comb begin
    wr_entry.pc    = in_data_i.next_pc & wfq_pkg::PcKeep;
    wr_entry.mask  = in_data_i.lane_mask & wfq_pkg::LaneKeep;
    wr_entry.warp  = in_data_i.warp_num;
    wr_entry.count = in_data_i.lane_count;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[tail_q] <= wr_entry;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[head_q];
    end
  end

  assign repeat_hit = last_valid_q && (rdata_q.pc == last_pc_q) &&
                      (rdata_q.warp == last_warp_q) && (rdata_q.mask == last_mask_q);

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    last_pc_d    = last_pc_q;
    last_warp_d  = last_warp_q;
    last_mask_d  = last_mask_q;
    last_valid_d = last_valid_q;
    halt_d       = halt_q;
    if (cmd_i.store) begin
      tail_d  = ring_next(tail_q);
      count_d = count_q + 1'b1;
    end
    if (cmd_i.pop_commit) begin
      head_d       = ring_next(head_q);
      count_d      = count_q - 1'b1;
      last_pc_d    = rdata_q.pc;
      last_warp_d  = rdata_q.warp;
      last_mask_d  = rdata_q.mask;
      last_valid_d = 1'b1;
      // warps past the configured count are tracked but never halted
      if (32'(rdata_q.warp) < wfq_pkg::NumWarps) begin
        halt_d[rdata_q.warp] = repeat_hit;
      end
    end
  end

  always_comb begin
    out_d                  = '0;
    out_d.status           = cmd_i.out_status;
    out_d.halt_bits        = halt_d;
    out_d.queued           = wfq_pkg::QueuedW'(count_d);
    if (cmd_i.pop_commit) begin
      out_d.fetch_pc         = rdata_q.pc;
      out_d.fetch_warp       = rdata_q.warp;
      out_d.fetch_mask       = rdata_q.mask;
      out_d.fetch_lane_count = rdata_q.count;
      out_d.warp_halted      = repeat_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      last_pc_q    <= '0;
      last_warp_q  <= '0;
      last_mask_q  <= wfq_pkg::LaneKeep;
      last_valid_q <= 1'b0;
      halt_q       <= '0;
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      last_pc_q    <= last_pc_d;
      last_warp_q  <= last_warp_d;
      last_mask_q  <= last_mask_d;
      last_valid_q <= last_valid_d;
      halt_q       <= halt_d;
    end
  end

endmodule

/* sv/warp_fetch_queue_halt_detect.sv */
`timescale 1ns / 1ps

// Fetch-request ring queue with repeat (halt) detection, 32 entries.
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat is a push
// (cmd 0) of pc, lane mask, warp and lane count, or a pop (cmd 1).
// Output channel (out_valid_o/out_ready_i/out_data_o): exactly one result
// beat per input beat, in order: status, the popped request, the repeat
// flag, the per-warp halt bits and the queue occupancy after the beat.
// A push, or a pop that finds the queue empty, loads its result into the
// output register on acceptance. A pop that hits an entry first does a
// registered read of the entry RAM, then compares against the last fetch
// and updates the halt bits while its result is loaded. One push per
// cycle while results are taken; a hitting pop blocks new beats until loaded.
// The result sits in an output register; a new beat is accepted while a
// result is being taken. If the receiver stalls, the result holds and
// in_ready_o stays low until the slot drains.
// Reset clears pointers, occupancy, last-fetch tracking and halt bits;
// the entry RAM is not cleared and needs no sweep.

module warp_fetch_queue_halt_detect (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wfq_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wfq_pkg::out_t  out_data_o
);

  wfq_pkg::dp_cmd_t dp_cmd;
  wfq_pkg::dp_sts_t dp_sts;

  wfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_cmd_i    (in_data_i.cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  wfq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .out_data_o (out_data_o)
  );

endmodule
